// ===== design/bel_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the boolean expression lexer.
// Depends on nothing; every other design file uses it by scoped names.
package bel_pkg;

   // Width of the internal identifier letter counter (saturating).
   localparam int LENGTH_BITS = 16;
   localparam int MAX_RESULTS = 4;

   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_LPAREN  = 4'd1,
      KIND_RPAREN  = 4'd2,
      KIND_OR      = 4'd3,
      KIND_AND     = 4'd4,
      KIND_NOT     = 4'd5,
      KIND_XOR     = 4'd6,
      KIND_IDEND   = 4'd7,
      KIND_ERROR   = 4'd8,
      KIND_IDCHAR  = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_KEYWORD = 2'd1,
      MODE_IDENT   = 2'd2,
      MODE_HALT    = 2'd3
   } mode_type;

   // Keyword slots, in the order of their token kinds.
   localparam logic [1:0] KW_OR  = 2'd0;
   localparam logic [1:0] KW_AND = 2'd1;
   localparam logic [1:0] KW_NOT = 2'd2;
   localparam logic [1:0] KW_XOR = 2'd3;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_D  = 8'h64;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_O  = 8'h6f;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LOW_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5a;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  ident_char;
      logic [15:0] ident_length;
      logic        last_of_run;
   } rsp_type;

   // All results caused by one request, oldest in slot 0.
   typedef struct packed {
      logic [2:0]                    count;
      rsp_type [MAX_RESULTS-1:0]     items;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [1:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case ({sel, pos})
         {KW_OR, 2'd0}:  ch = CH_LOW_O;
         {KW_OR, 2'd1}:  ch = CH_LOW_R;
         {KW_AND, 2'd0}: ch = CH_LOW_A;
         {KW_AND, 2'd1}: ch = CH_LOW_N;
         {KW_AND, 2'd2}: ch = CH_LOW_D;
         {KW_NOT, 2'd0}: ch = CH_LOW_N;
         {KW_NOT, 2'd1}: ch = CH_LOW_O;
         {KW_NOT, 2'd2}: ch = CH_LOW_T;
         {KW_XOR, 2'd0}: ch = CH_LOW_X;
         {KW_XOR, 2'd1}: ch = CH_LOW_O;
         {KW_XOR, 2'd2}: ch = CH_LOW_R;
         default:        ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] kw_len(input logic [1:0] sel);
      return (sel == KW_OR) ? 2'd2 : 2'd3;
   endfunction

   function automatic rsp_type make_item(input kind_type kind, input logic [7:0] ch,
                                         input logic [LENGTH_BITS-1:0] count);
      rsp_type     item;
      logic [31:0] wide;
      wide              = 32'(count);
      item.kind         = kind;
      item.ident_char   = ch;
      item.ident_length = wide[15:0];
      item.last_of_run  = 1'b0;
      return item;
   endfunction

endpackage

// ===== design/bel_front.sv =====
`timescale 1ns / 1ps
// Front end of the lexer: accepts bytes, runs the scan state and builds the
// bundle of results each request causes. Depends on bel_pkg.
module bel_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bel_pkg::req_type          req_data,
   input  bel_pkg::queue_status_type q_status,
   output logic                      push,
   output bel_pkg::bundle_type       push_bundle
);

   bel_pkg::mode_type                 mode_ff, mode_in;
   logic [1:0]                        ksel_ff, ksel_in;
   logic [1:0]                        mcnt_ff, mcnt_in;
   logic [bel_pkg::LENGTH_BITS-1:0]   icnt_ff, icnt_in;

   logic                              accept;
   logic [7:0]                        c;
   logic                              eot;
   logic                              is_letter, is_blank, is_kw_start, kw_match;
   logic                              handled;
   logic [2:0]                        n;
   bel_pkg::rsp_type [bel_pkg::MAX_RESULTS-1:0] items;
   bel_pkg::kind_type                 kw_kind;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign c         = req_data.char_code;
   assign eot       = req_data.end_of_text;

   always_comb begin
      is_letter   = (c inside {[bel_pkg::CH_LOW_A:bel_pkg::CH_LOW_Z],
                               [bel_pkg::CH_UP_A:bel_pkg::CH_UP_Z]});
      is_blank    = (c inside {bel_pkg::CH_SPACE, bel_pkg::CH_CR, bel_pkg::CH_LF,
                               bel_pkg::CH_TAB});
      is_kw_start = (c inside {bel_pkg::CH_LOW_O, bel_pkg::CH_LOW_A, bel_pkg::CH_LOW_N,
                               bel_pkg::CH_LOW_X});
      kw_match    = (mcnt_ff < bel_pkg::kw_len(ksel_ff)) &&
                    (c == bel_pkg::kw_char(ksel_ff, mcnt_ff));
      kw_kind     = bel_pkg::kind_type'(4'(bel_pkg::KIND_OR) + {2'b00, ksel_ff});
   end

   always_comb begin
      mode_in = mode_ff;
      ksel_in = ksel_ff;
      mcnt_in = mcnt_ff;
      icnt_in = icnt_ff;
      n       = 3'd0;
      handled = 1'b0;
      items   = '0;

      if (mode_ff != bel_pkg::MODE_HALT) begin
         // A matching keyword letter needs no spill; any other byte in keyword mode
         // turns the held prefix into identifier letters first.
         if (mode_ff == bel_pkg::MODE_KEYWORD && !eot && kw_match) begin
            handled = 1'b1;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_in >= bel_pkg::kw_len(ksel_ff)) begin
               items[0] = bel_pkg::make_item(kw_kind, 8'h00, '0);
               n        = 3'd1;
               ksel_in  = bel_pkg::KW_OR;
               mcnt_in  = 2'd0;
               mode_in  = bel_pkg::MODE_IDLE;
            end
         end else if (mode_ff == bel_pkg::MODE_KEYWORD) begin
            icnt_in = '0;
            for (int i = 0; i < 2; i++) begin
               if (2'(i) < mcnt_ff) begin
                  icnt_in = icnt_in + bel_pkg::LENGTH_BITS'(1);
                  items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_IDCHAR,
                                     bel_pkg::kw_char(ksel_ff, 2'(i)), '0);
                  n = n + 3'd1;
               end
            end
            ksel_in = bel_pkg::KW_OR;
            mcnt_in = 2'd0;
            mode_in = bel_pkg::MODE_IDENT;
         end

         if (!handled && eot) begin
            if (mode_in == bel_pkg::MODE_IDENT) begin
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_IDEND, 8'h00, icnt_in);
               n = n + 3'd1;
            end
            items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_END, 8'h00, '0);
            n       = n + 3'd1;
            mode_in = bel_pkg::MODE_IDLE;
            ksel_in = bel_pkg::KW_OR;
            mcnt_in = 2'd0;
            icnt_in = '0;
            handled = 1'b1;
         end

         if (!handled && mode_in == bel_pkg::MODE_IDENT) begin
            if (is_letter) begin
               if (icnt_in != '1) begin
                  icnt_in = icnt_in + bel_pkg::LENGTH_BITS'(1);
               end
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_IDCHAR, c, '0);
               n       = n + 3'd1;
               handled = 1'b1;
            end else begin
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_IDEND, 8'h00, icnt_in);
               n       = n + 3'd1;
               icnt_in = '0;
               mode_in = bel_pkg::MODE_IDLE;
            end
         end

         if (!handled) begin
            if (is_blank) begin
               mode_in = bel_pkg::MODE_IDLE;
            end else if (c == bel_pkg::CH_LPAREN) begin
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_LPAREN, 8'h00, '0);
               n = n + 3'd1;
            end else if (c == bel_pkg::CH_RPAREN) begin
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_RPAREN, 8'h00, '0);
               n = n + 3'd1;
            end else if (is_kw_start) begin
               case (c)
                  bel_pkg::CH_LOW_O: ksel_in = bel_pkg::KW_OR;
                  bel_pkg::CH_LOW_A: ksel_in = bel_pkg::KW_AND;
                  bel_pkg::CH_LOW_N: ksel_in = bel_pkg::KW_NOT;
                  default:           ksel_in = bel_pkg::KW_XOR;
               endcase
               mcnt_in = 2'd1;
               mode_in = bel_pkg::MODE_KEYWORD;
            end else if (is_letter) begin
               icnt_in = bel_pkg::LENGTH_BITS'(1);
               mode_in = bel_pkg::MODE_IDENT;
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_IDCHAR, c, '0);
               n = n + 3'd1;
            end else begin
               mode_in = bel_pkg::MODE_HALT;
               items[n[1:0]] = bel_pkg::make_item(bel_pkg::KIND_ERROR, 8'h00, '0);
               n = n + 3'd1;
            end
         end

         if (n != 3'd0) begin
            items[2'(n - 3'd1)].last_of_run = 1'b1;
         end
      end
   end

   assign push              = accept && (n != 3'd0);
   assign push_bundle.count = n;
   assign push_bundle.items = items;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bel_pkg::MODE_IDLE;
         ksel_ff <= bel_pkg::KW_OR;
         mcnt_ff <= 2'd0;
         icnt_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         ksel_ff <= ksel_in;
         mcnt_ff <= mcnt_in;
         icnt_ff <= icnt_in;
      end
   end

endmodule

// ===== design/bel_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of result bundles between the lexer front and back ends.
// Depends on bel_pkg.
module bel_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bel_pkg::bundle_type       push_bundle,
   input  logic                      pop,
   output bel_pkg::bundle_type       head,
   output bel_pkg::queue_status_type q_status
);

   bel_pkg::bundle_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ===== design/bel_back.sv =====
`timescale 1ns / 1ps
// Back end of the lexer: walks the head bundle one result per cycle, while the
// output is not stalled, into the output register. Depends on bel_pkg.
module bel_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bel_pkg::bundle_type       head,
   input  bel_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bel_pkg::rsp_type          rsp_data
);

   logic [1:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   bel_pkg::rsp_type out_ff;
   logic             load;
   logic             last_slot;

   assign load      = !q_status.empty && (!out_valid_ff || !rsp_stall);
   assign last_slot = ({1'b0, idx_ff} == (head.count - 3'd1));
   assign pop       = load && last_slot;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = last_slot ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= head.items[idx_ff];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== design/boolean_expression_lexer.sv =====
`timescale 1ns / 1ps
// Boolean expression lexer, top level. A request is taken every cycle while the
// two-entry bundle queue has room; its results pass through a queue entry and
// then the output register. Results leave at one per cycle while rsp_stall is low,
// and a request that causes no results puts nothing into the queue.
// Synchronous reset returns the scanner to between-tokens and empties the queue.
module boolean_expression_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bel_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bel_pkg::rsp_type    rsp_data
);

   bel_pkg::queue_status_type q_status;
   bel_pkg::bundle_type       push_bundle;
   bel_pkg::bundle_type       head;
   logic                      push;
   logic                      pop;

   bel_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_status    (q_status),
      .push        (push),
      .push_bundle (push_bundle)
   );

   bel_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .q_status    (q_status)
   );

   bel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
